// ===== design/byte_ring_buffer_push_pop_defines.svh =====
`ifndef BYTE_RING_BUFFER_PUSH_POP_DEFINES_SVH
`define BYTE_RING_BUFFER_PUSH_POP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BRB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("byte ring buffer check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("byte ring buffer check failed");

`endif

// ===== design/brb_pkg.sv =====
package brb_pkg;

  localparam int CAPACITY = 8;
  localparam int DEPTH    = 8;
  localparam logic [3:0] CAP_W4 = 4'(CAPACITY);
  localparam logic [4:0] CAP_W5 = 5'(CAPACITY);

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ARG   = 2'd1;
  localparam logic [1:0] ST_NO_ROOM   = 2'd2;
  localparam logic [1:0] ST_OVER_PULL = 2'd3;

  typedef struct packed {
    logic        func;
    logic [3:0]  count;
    logic [63:0] data_bytes;
  } brb_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  write_offset;
    logic [3:0]  first_len;
    logic [2:0]  second_len;
    logic [3:0]  fill_level;
    logic [2:0]  read_position;
    logic [63:0] buffer_contents;
  } brb_out_t;

  typedef struct packed {
    logic       en;
    logic [2:0] woff;
    logic [3:0] count;
  } brb_wr_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] woff;
    logic [3:0] first;
    logic [2:0] second;
  } brb_res_t;

endpackage

// ===== design/brb_lane.sv =====
module brb_lane
  import brb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  lane_idx,
  input  brb_wr_t     wr,
  input  logic [63:0] data_bytes,
  output logic [7:0]  lane_byte
);

  logic [7:0] lane_byte_r;
  logic [7:0] lane_byte_nxt;
  logic [3:0] gap;
  logic [3:0] rel;
  logic       hit;

  always_comb begin
    gap  = {1'b0, lane_idx} + CAP_W4 - {1'b0, wr.woff};
    rel  = (gap >= CAP_W4) ? gap - CAP_W4 : gap;
    hit  = wr.en && (rel < wr.count);
    lane_byte_nxt = hit ? data_bytes[{rel[2:0], 3'b000} +: 8] : lane_byte_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_byte_r <= '0;
    end else begin
      lane_byte_r <= lane_byte_nxt;
    end
  end

  assign lane_byte = lane_byte_r;

endmodule

// ===== design/brb_ctrl.sv =====
module brb_ctrl
  import brb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  brb_in_t    in_data,
  output brb_wr_t    wr,
  output brb_res_t   res,
  output logic       res_valid,
  output logic [2:0] start_idx,
  output logic [3:0] held
);

  logic [2:0] start_r, start_nxt;
  logic [3:0] held_r, held_nxt;
  logic       res_valid_r;
  brb_res_t   res_r, res_nxt;

  logic [3:0] push_sum;
  logic [3:0] woff4;
  logic [3:0] span;
  logic [3:0] first;
  logic [4:0] pop_sum;
  logic [4:0] pop_wrap;
  logic       no_room;

  always_comb begin
    push_sum = {1'b0, start_r} + held_r;
    woff4    = (push_sum >= CAP_W4) ? push_sum - CAP_W4 : push_sum;
    span     = CAP_W4 - woff4;
    first    = (span > in_data.count) ? in_data.count : span;
    no_room  = ({1'b0, held_r} + {1'b0, in_data.count}) > CAP_W5;
    pop_sum  = {2'b00, start_r} + {1'b0, in_data.count};
    pop_wrap = (pop_sum >= CAP_W5) ? pop_sum - CAP_W5 : pop_sum;

    wr.en      = 1'b0;
    wr.woff    = woff4[2:0];
    wr.count   = in_data.count;
    res_nxt    = '0;
    start_nxt  = start_r;
    held_nxt   = held_r;

    priority if (in_data.count == 4'd0) begin
      res_nxt.status = ST_BAD_ARG;
    end else if (in_data.func == FUNC_PUSH) begin
      if (no_room) begin
        res_nxt.status = ST_NO_ROOM;
      end else begin
        res_nxt.status = ST_OK;
        res_nxt.woff   = woff4[2:0];
        res_nxt.first  = first;
        res_nxt.second = 3'(in_data.count - first);
        wr.en          = go;
        held_nxt       = held_r + in_data.count;
      end
    end else begin
      if (in_data.count > held_r) begin
        res_nxt.status = ST_OVER_PULL;
      end else begin
        res_nxt.status = ST_OK;
        held_nxt       = held_r - in_data.count;
        start_nxt      = pop_wrap[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      held_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= go;
      if (go) begin
        start_r <= start_nxt;
        held_r  <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res_nxt;
    end
  end

  assign res       = res_r;
  assign res_valid = res_valid_r;
  assign start_idx = start_r;
  assign held      = held_r;

endmodule

// ===== design/byte_ring_buffer_push_pop.sv =====
// The result word strobes on out_valid in the cycle after start is taken.
// Throughput: one word per cycle while busy is low; all eight byte lanes and both pointers update together.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (rst_n low, synchronous): storage, start position and fill level clear to zero;
// busy stays high for the cycle after reset is released.
module byte_ring_buffer_push_pop
  import brb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  brb_in_t  in_data,
  output logic     out_valid,
  output brb_out_t out_data
);

  logic        busy_r;
  logic        go;
  brb_wr_t     wr;
  brb_res_t    res;
  logic [2:0]  start_idx;
  logic [3:0]  held;
  logic [63:0] contents;

  assign go = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .in_data   (in_data),
    .wr        (wr),
    .res       (res),
    .res_valid (out_valid),
    .start_idx (start_idx),
    .held      (held)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_lane
    if (g < CAPACITY) begin : g_used
      brb_lane u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_idx   (3'(g)),
        .wr         (wr),
        .data_bytes (in_data.data_bytes),
        .lane_byte  (contents[8*g +: 8])
      );
    end else begin : g_unused
      assign contents[8*g +: 8] = 8'h00;
    end
  end

  // merge lane bytes and pointer state into the result word
  always_comb begin
    out_data.status          = res.status;
    out_data.write_offset    = res.woff;
    out_data.first_len       = res.first;
    out_data.second_len      = res.second;
    out_data.fill_level      = held;
    out_data.read_position   = start_idx;
    out_data.buffer_contents = contents;
  end

  assign busy = busy_r;

endmodule

// ===== design/brb_checker.sv =====
`include "byte_ring_buffer_push_pop_defines.svh"

module brb_checker
  import brb_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input brb_in_t  in_data,
  input logic     out_valid,
  input brb_out_t out_data
);

  logic taken;

  assign taken = start && !busy;

  `BRB_ASSERT_NEXT(a_word_answered, taken, out_valid)
  `BRB_ASSERT_NEXT(a_no_stray_word, !taken, !out_valid)
  `BRB_ASSERT_NOW(a_error_zero_span, out_valid && (out_data.status != ST_OK),
    (out_data.write_offset == 3'd0) && (out_data.first_len == 4'd0) && (out_data.second_len == 3'd0))
  `BRB_ASSERT_NOW(a_fill_bounded, out_valid, out_data.fill_level <= CAP_W4)
  `BRB_ASSERT_NEXT(a_push_split, taken && (in_data.func == FUNC_PUSH),
    (out_data.status != ST_OK) || ((out_data.first_len + 4'(out_data.second_len)) == $past(in_data.count)))

endmodule

bind byte_ring_buffer_push_pop brb_checker u_brb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ===== verif/brb_ring_checker.sv =====
`timescale 1ns / 1ps

module brb_ring_checker
  import brb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  brb_in_t  in_data,
  input  logic     out_valid,
  input  brb_out_t out_data,
  output int       errors,
  output int       pending,
  output int       words_checked,
  output int       wraps_seen
);

  logic [7:0] ring_bytes [DEPTH];
  int         ring_start;
  int         ring_held;
  brb_out_t   awaited_results [$];

  initial begin
    errors        = 0;
    pending       = 0;
    words_checked = 0;
    wraps_seen    = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  task automatic ring_model_step(input brb_in_t w, output brb_out_t r);
    int pos;
    int room;
    int n;
    n = int'(w.count);
    r = '0;
    r.status = ST_OK;
    if (n == 0) begin
      r.status = ST_BAD_ARG;
    end else if (w.func == FUNC_PUSH) begin
      if (ring_held + n > CAPACITY) begin
        r.status = ST_NO_ROOM;
      end else begin
        pos  = (ring_start + ring_held) % CAPACITY;
        room = CAPACITY - pos;
        r.write_offset = 3'(pos);
        r.first_len    = 4'((room < n) ? room : n);
        r.second_len   = 3'(n - ((room < n) ? room : n));
        for (int i = 0; i < n; i++) begin
          ring_bytes[(pos + i) % CAPACITY] = w.data_bytes[8*i +: 8];
        end
        ring_held += n;
      end
    end else begin
      if (n > ring_held) begin
        r.status = ST_OVER_PULL;
      end else begin
        ring_held -= n;
        ring_start = (ring_start + n) % CAPACITY;
      end
    end
    r.fill_level    = 4'(ring_held);
    r.read_position = 3'(ring_start);
    for (int i = 0; i < DEPTH; i++) begin
      r.buffer_contents[8*i +: 8] = ring_bytes[i];
    end
  endtask

  always @(posedge clk) begin
    brb_out_t want;
    brb_out_t fresh;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) ring_bytes[i] = 8'h00;
      ring_start = 0;
      ring_held  = 0;
      awaited_results.delete();
    end else begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result word", out_data.buffer_contents, '0);
        end else begin
          want = awaited_results.pop_front();
          words_checked++;
          if (out_data.status !== want.status)
            report_mismatch("status", 64'(out_data.status), 64'(want.status));
          if (out_data.write_offset !== want.write_offset)
            report_mismatch("write_offset", 64'(out_data.write_offset),
                            64'(want.write_offset));
          if (out_data.first_len !== want.first_len)
            report_mismatch("first_len", 64'(out_data.first_len), 64'(want.first_len));
          if (out_data.second_len !== want.second_len)
            report_mismatch("second_len", 64'(out_data.second_len),
                            64'(want.second_len));
          if (out_data.fill_level !== want.fill_level)
            report_mismatch("fill_level", 64'(out_data.fill_level),
                            64'(want.fill_level));
          if (out_data.read_position !== want.read_position)
            report_mismatch("read_position", 64'(out_data.read_position),
                            64'(want.read_position));
          if (out_data.buffer_contents !== want.buffer_contents)
            report_mismatch("buffer_contents", out_data.buffer_contents,
                            want.buffer_contents);
        end
      end
      if (start && !busy) begin
        ring_model_step(in_data, fresh);
        if (fresh.second_len != 0) wraps_seen++;
        awaited_results.push_back(fresh);
      end
    end
    pending = awaited_results.size();
  end

endmodule

// ===== verif/byte_ring_buffer_push_pop_tb.sv =====
`timescale 1ns / 1ps

module byte_ring_buffer_push_pop_tb;
  import brb_pkg::*;

  localparam int RANDOM_WORDS = 500;
  localparam int QUIET_TAIL   = 100;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  brb_in_t  in_data;
  logic     out_valid;
  brb_out_t out_data;

  int errors;
  int pending;
  int words_checked;
  int wraps_seen;
  int cycle_count;
  int level_guess;
  int directed_sent;
  int random_sent;

  byte_ring_buffer_push_pop u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  brb_ring_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .errors       (errors),
    .pending      (pending),
    .words_checked(words_checked),
    .wraps_seen   (wraps_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic brb_in_t mk_word(input logic f, input logic [3:0] n,
                                      input logic [63:0] d);
    brb_in_t w;
    w.func       = f;
    w.count      = n;
    w.data_bytes = d;
    return w;
  endfunction

  // call at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input brb_in_t w);
    int n;
    n = int'(w.count);
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (n != 0) begin
      if (w.func == FUNC_PUSH && level_guess + n <= CAPACITY) level_guess += n;
      if (w.func == FUNC_POP && n <= level_guess) level_guess -= n;
    end
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 17)) @(negedge clk);
  endtask

  task automatic random_word();
    int kind;
    logic [63:0] d;
    kind = $urandom_range(0, 99);
    d = {$urandom, $urandom};
    if (kind < 85) begin
      if (level_guess == 0 || (level_guess < CAPACITY && $urandom_range(0, 1) == 1))
        send_word(mk_word(FUNC_PUSH, 4'($urandom_range(1, CAPACITY - level_guess)), d));
      else
        send_word(mk_word(FUNC_POP, 4'($urandom_range(1, level_guess)), d));
    end else if (kind < 90) begin
      send_word(mk_word(1'($urandom_range(0, 1)), 4'd0, d));
    end else begin
      send_word(mk_word(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), d));
    end
  endtask

  initial begin
    level_guess   = 0;
    directed_sent = 0;
    random_sent   = 0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_word(mk_word(FUNC_PUSH, 4'd0,  64'h0));
    send_word(mk_word(FUNC_POP,  4'd0,  ALL_ONES));
    send_word(mk_word(FUNC_POP,  4'd1,  64'h0));
    send_word(mk_word(FUNC_PUSH, 4'd8,  ALL_ONES));
    send_word(mk_word(FUNC_PUSH, 4'd1,  64'h5A));
    send_word(mk_word(FUNC_PUSH, 4'd15, ALL_ONES));
    send_word(mk_word(FUNC_POP,  4'd8,  64'h0));
    send_word(mk_word(FUNC_PUSH, 4'd5,  64'h0000_0005_0403_0201));
    send_word(mk_word(FUNC_POP,  4'd3,  64'h0));
    send_word(mk_word(FUNC_PUSH, 4'd6,  64'h0000_1615_1413_1211));
    send_word(mk_word(FUNC_POP,  4'd9,  64'h0));
    send_word(mk_word(FUNC_PUSH, 4'd8,  64'h0));
    send_word(mk_word(FUNC_POP,  4'd8,  64'h0));
    send_word(mk_word(FUNC_PUSH, 4'd4,  64'hA5A5_A5A5_C3C3_C3C3));
    send_word(mk_word(FUNC_POP,  4'd4,  64'h0));
    send_word(mk_word(FUNC_PUSH, 4'd8,  64'h8877_6655_4433_2211));
    send_word(mk_word(FUNC_POP,  4'd15, ALL_ONES));
    send_word(mk_word(FUNC_POP,  4'd1,  64'h0));
    send_word(mk_word(FUNC_PUSH, 4'd1,  ALL_ONES));
    send_word(mk_word(FUNC_POP,  4'd8,  64'h0));
    send_word(mk_word(FUNC_PUSH, 4'd8,  64'h0));
    send_word(mk_word(FUNC_POP,  4'd8,  64'h0));
    directed_sent = 22;

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) begin
        // hold until the ring has answered everything
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      random_word();
      random_sent++;
      if (i < RANDOM_WORDS - QUIET_TAIL && $urandom_range(0, 3) == 0) idle_burst();
    end
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("covered %0d directed and %0d random words, %0d results checked",
             directed_sent, random_sent, words_checked);
    $display("pushes wrapping past the end of storage: %0d", wraps_seen);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
